// ===== sv/lisp_token_scanner_assert.svh =====
// Assertion macros for the lisp token scanner.
// Each use names its label and expects clk_i and rst_ni in scope.
`ifndef LISP_TOKEN_SCANNER_ASSERT_SVH
`define LISP_TOKEN_SCANNER_ASSERT_SVH

// Same-cycle implication.
`define LTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lisp_token_scanner: same-cycle check failed");

// Next-cycle implication.
`define LTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lisp_token_scanner: next-cycle check failed");

`endif

// ===== sv/lts_pkg.sv =====
// Shared types and constants of the lisp token scanner.
// No dependencies; used by every module of the block.
package lts_pkg;

  localparam int ROW_BITS         = 16;
  localparam int COL_BITS         = 16;
  localparam int LEN_BITS         = 8;
  localparam int MAX_TOKEN_LENGTH = 255;
  localparam int VALUE_BITS       = 64;
  localparam int KIND_BITS        = 4;
  localparam int BASE_BITS        = 5;
  localparam int Q_DEPTH          = 4;
  localparam int Q_PTR_BITS       = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_SYMBOL,
    MODE_COMMENT
  } scan_mode_e;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_NUMBER   = 4'd0,
    KIND_SYMBOL   = 4'd1,
    KIND_LPAREN   = 4'd2,
    KIND_RPAREN   = 4'd3,
    KIND_LBRACE   = 4'd4,
    KIND_RBRACE   = 4'd5,
    KIND_LBRACKET = 4'd6,
    KIND_RBRACKET = 4'd7,
    KIND_QUOTE    = 4'd8,
    KIND_BACKTICK = 4'd9,
    KIND_TILDE    = 4'd10,
    KIND_AT       = 4'd11,
    KIND_CARET    = 4'd12,
    KIND_END      = 4'd13
  } tok_kind_e;

  localparam logic [BASE_BITS-1:0] BASE_BIN   = 5'd2;
  localparam logic [BASE_BITS-1:0] BASE_OCT   = 5'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC   = 5'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX   = 5'd16;
  localparam logic [BASE_BITS-1:0] DIGIT_NONE = 5'd17;

  localparam logic [7:0] CH_NEWLINE  = 8'h0a;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h27;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_F  = 8'h46;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_CARET    = 8'h5e;
  localparam logic [7:0] CH_BACKTICK = 8'h60;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_B  = 8'h62;
  localparam logic [7:0] CH_LOWER_F  = 8'h66;
  localparam logic [7:0] CH_LOWER_O  = 8'h6f;
  localparam logic [7:0] CH_LOWER_X  = 8'h78;
  localparam logic [7:0] CH_LBRACE   = 8'h7b;
  localparam logic [7:0] CH_RBRACE   = 8'h7d;
  localparam logic [7:0] CH_TILDE    = 8'h7e;

  typedef struct packed {
    tok_kind_e               kind;
    logic [ROW_BITS-1:0]     row;
    logic [COL_BITS-1:0]     col;
    logic [LEN_BITS-1:0]     len;
    logic [VALUE_BITS-1:0]   value;
  } token_t;

  // One queue entry holds every word caused by one character.
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/lts_front.sv =====
// Front end of the lisp token scanner: accepts characters, tracks scan state,
// and builds the queue entry of finished tokens. Depends on lts_pkg.
module lts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_code_i,
  input  logic              end_of_source_i,
  input  lts_pkg::q_status_t q_status_i,
  output logic              push_o,
  output lts_pkg::q_entry_t entry_o
);
  import lts_pkg::*;

  function automatic logic [BASE_BITS-1:0] digit_of(input logic [7:0] ch);
    logic [7:0] diff;
    diff = 8'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      diff = ch - CH_ZERO;
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
      diff = ch - CH_LOWER_A + 8'd10;
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
      diff = ch - CH_UPPER_A + 8'd10;
    end else begin
      diff = {3'd0, DIGIT_NONE};
    end
    return diff[BASE_BITS-1:0];
  endfunction

  scan_mode_e            mode_q, mode_d;
  logic [BASE_BITS-1:0]  base_q, base_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [ROW_BITS-1:0]   open_row_q, open_row_d;
  logic [COL_BITS-1:0]   open_col_q, open_col_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [ROW_BITS-1:0]   line_q, line_d;
  logic [COL_BITS-1:0]   col_q, col_d;
  logic                  finished_q, finished_d;

  logic                  accept;
  logic                  is_nl, is_space, is_semi, is_digit, is_single;
  tok_kind_e             single_kind;
  logic [BASE_BITS-1:0]  digit;
  logic [VALUE_BITS-1:0] acc_scaled;
  logic [LEN_BITS-1:0]   len_grown;
  logic                  flush_valid;
  token_t                flush_tok, second_tok;
  logic                  emit_flush, emit_second, restart;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  assign is_nl    = (char_code_i == CH_NEWLINE);
  assign is_space = (char_code_i == CH_SPACE);
  assign is_semi  = (char_code_i == CH_SEMI);
  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign digit    = digit_of(char_code_i);

  always_comb begin
    is_single   = 1'b1;
    single_kind = KIND_END;
    unique case (char_code_i)
      CH_LPAREN:   single_kind = KIND_LPAREN;
      CH_RPAREN:   single_kind = KIND_RPAREN;
      CH_LBRACE:   single_kind = KIND_LBRACE;
      CH_RBRACE:   single_kind = KIND_RBRACE;
      CH_LBRACKET: single_kind = KIND_LBRACKET;
      CH_RBRACKET: single_kind = KIND_RBRACKET;
      CH_QUOTE:    single_kind = KIND_QUOTE;
      CH_BACKTICK: single_kind = KIND_BACKTICK;
      CH_TILDE:    single_kind = KIND_TILDE;
      CH_AT:       single_kind = KIND_AT;
      CH_CARET:    single_kind = KIND_CARET;
      default:     is_single   = 1'b0;
    endcase
  end

  // Scale by the base with shifts, plus one add for decimal.
  always_comb begin
    case (base_q)
      BASE_BIN: acc_scaled = acc_q << 1;
      BASE_OCT: acc_scaled = acc_q << 3;
      BASE_HEX: acc_scaled = acc_q << 4;
      default:  acc_scaled = (acc_q << 3) + (acc_q << 1);
    endcase
  end

  assign len_grown = (len_q < LEN_BITS'(MAX_TOKEN_LENGTH)) ? len_q + 1'b1 : len_q;

  // A prefix with no digits is dropped.
  assign flush_valid = (mode_q == MODE_SYMBOL) ||
                       ((mode_q == MODE_NUMBER) &&
                        !((base_q != BASE_DEC) && (len_q <= LEN_BITS'(2))));

  always_comb begin
    flush_tok.kind  = (mode_q == MODE_NUMBER) ? KIND_NUMBER : KIND_SYMBOL;
    flush_tok.row   = open_row_q;
    flush_tok.col   = open_col_q;
    flush_tok.len   = len_q;
    flush_tok.value = (mode_q == MODE_NUMBER) ? acc_q : '0;
  end

  always_comb begin
    mode_d      = mode_q;
    base_d      = base_q;
    acc_d       = acc_q;
    open_row_d  = open_row_q;
    open_col_d  = open_col_q;
    len_d       = len_q;
    line_d      = line_q;
    col_d       = col_q;
    finished_d  = finished_q;
    restart     = 1'b0;
    emit_flush  = 1'b0;
    emit_second = 1'b0;
    second_tok.kind  = single_kind;
    second_tok.row   = line_q;
    second_tok.col   = col_q;
    second_tok.len   = LEN_BITS'(1);
    second_tok.value = '0;

    if (accept && !finished_q) begin
      if (end_of_source_i) begin
        emit_flush      = flush_valid;
        emit_second     = 1'b1;
        second_tok.kind = KIND_END;
        mode_d          = MODE_IDLE;
        finished_d      = 1'b1;
      end else begin
        unique case (mode_q)
          MODE_COMMENT: begin
            if (is_nl) mode_d = MODE_IDLE;
          end
          MODE_NUMBER: begin
            if ((base_q == BASE_DEC) && (len_q == LEN_BITS'(1)) && (acc_q == '0) &&
                (char_code_i == CH_LOWER_B || char_code_i == CH_LOWER_O ||
                 char_code_i == CH_LOWER_X)) begin
              base_d = (char_code_i == CH_LOWER_B) ? BASE_BIN :
                       (char_code_i == CH_LOWER_O) ? BASE_OCT : BASE_HEX;
              len_d  = len_grown;
            end else if (digit < base_q) begin
              acc_d = acc_scaled + {{(VALUE_BITS-BASE_BITS){1'b0}}, digit};
              len_d = len_grown;
            end else begin
              restart = 1'b1;
            end
          end
          MODE_SYMBOL: begin
            if (is_space || is_nl || is_single) restart = 1'b1;
            else len_d = len_grown;
          end
          MODE_IDLE: restart = 1'b1;
          default:   restart = 1'b1;
        endcase

        // Close the open token and scan this character as a new start.
        if (restart) begin
          emit_flush = flush_valid;
          open_row_d = line_q;
          open_col_d = col_q;
          len_d      = LEN_BITS'(1);
          if (is_space || is_nl) begin
            mode_d = MODE_IDLE;
          end else if (is_semi) begin
            mode_d = MODE_COMMENT;
          end else if (is_digit) begin
            mode_d = MODE_NUMBER;
            base_d = BASE_DEC;
            acc_d  = {{(VALUE_BITS-4){1'b0}}, char_code_i[3:0]};
          end else if (is_single) begin
            mode_d      = MODE_IDLE;
            emit_second = 1'b1;
          end else begin
            mode_d = MODE_SYMBOL;
          end
        end

        if (is_nl) begin
          if (line_q != '1) line_d = line_q + 1'b1;
          col_d = '0;
        end else if (col_q != '1) begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  assign push_o         = emit_flush || emit_second;
  assign entry_o.first  = emit_flush ? flush_tok : second_tok;
  assign entry_o.second = second_tok;
  assign entry_o.two    = emit_flush && emit_second;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      base_q     <= BASE_DEC;
      acc_q      <= '0;
      open_row_q <= '0;
      open_col_q <= '0;
      len_q      <= '0;
      line_q     <= '0;
      col_q      <= '0;
      finished_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      base_q     <= base_d;
      acc_q      <= acc_d;
      open_row_q <= open_row_d;
      open_col_q <= open_col_d;
      len_q      <= len_d;
      line_q     <= line_d;
      col_q      <= col_d;
      finished_q <= finished_d;
    end
  end

endmodule

// ===== sv/lts_queue.sv =====
// Short entry queue between scanner front and output back end.
// Depends on lts_pkg for the entry type and depth.
module lts_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lts_pkg::q_entry_t  entry_i,
  input  logic               pop_i,
  output lts_pkg::q_entry_t  head_o,
  output lts_pkg::q_status_t status_o
);
  import lts_pkg::*;

  q_entry_t              slots_q [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wptr_q, rptr_q;
  logic [Q_PTR_BITS:0]   count_q;
  logic                  do_push, do_pop;

  assign status_o.full  = (count_q == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == Q_PTR_BITS'(Q_DEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == Q_PTR_BITS'(Q_DEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== sv/lts_back.sv =====
// Back end of the lisp token scanner: splits queue entries into output words
// and holds them in the output register. Depends on lts_pkg.
module lts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lts_pkg::q_entry_t  head_i,
  input  lts_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lts_pkg::token_t    word_o,
  output logic               last_o
);
  import lts_pkg::*;

  token_t word_q;
  logic   valid_q, last_q, sel_q;
  logic   load, take, split;

  assign load  = !valid_q || !out_stall_i;
  assign take  = load && !q_status_i.empty;
  // First word of a two-word entry leaves the entry in the queue.
  assign split = !sel_q && head_i.two;
  assign pop_o = take && !split;

  always_ff @(posedge clk_i) begin
    if (take) word_q <= sel_q ? head_i.second : head_i.first;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= !q_status_i.empty;
      if (take) begin
        last_q <= !split;
        sel_q  <= split;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;
  assign last_o      = last_q;

endmodule

// ===== sv/lisp_token_scanner.sv =====
// Lisp token scanner top level: front end, entry queue and back end.
// Depends on lts_pkg, lts_front, lts_queue, lts_back and the assert header.
//
// Usage:
//   Input channel: one source byte per word (char_code_i), or an end marker
//   (end_of_source_i high) that flushes the open token and emits the end token.
//   Output channel: one token per word, with last_of_run_o high on the final
//   token caused by an input word. A character gives zero, one or two tokens.
//   Throughput: one input word per cycle while in_stall_o is low; the front end scans
//   a character combinationally, with the number update done as shifts and adds.
//   Output: one token per cycle while out_stall_i is low and the queue holds
//   an entry, from the single output register. A token that an input word
//   completes passes through the queue and then the output register.
//   A four-entry queue decouples the sides; in_stall_o rises only when it is
//   full, so a stalled receiver backs up the input once four entries wait.
//   Reset clears the scan state to idle at row 0, column 0 and empties the
//   queue. After the end token, input words are taken and give nothing.
`include "lisp_token_scanner_assert.svh"

module lisp_token_scanner (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           char_code_i,
  input  logic                                 end_of_source_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lts_pkg::KIND_BITS-1:0]        tok_kind_o,
  output logic [lts_pkg::ROW_BITS-1:0]         start_row_o,
  output logic [lts_pkg::COL_BITS-1:0]         start_column_o,
  output logic [lts_pkg::LEN_BITS-1:0]         token_length_o,
  output logic signed [lts_pkg::VALUE_BITS-1:0] number_value_o,
  output logic                                 last_of_run_o
);
  import lts_pkg::*;

  logic      push, pop;
  q_entry_t  entry, head;
  q_status_t q_status;
  token_t    word;

  lts_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_source_i(end_of_source_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .entry_o        (entry)
  );

  lts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(q_status)
  );

  lts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .word_o     (word),
    .last_o     (last_of_run_o)
  );

  assign tok_kind_o     = word.kind;
  assign start_row_o    = word.row;
  assign start_column_o = word.col;
  assign token_length_o = word.len;
  assign number_value_o = $signed(word.value);

  `LTS_ASSERT_IMPL(a_no_push_when_full, push, !q_status.full)
  `LTS_ASSERT_IMPL(a_end_is_last, out_valid_o && tok_kind_o == KIND_END, last_of_run_o)
  `LTS_ASSERT_IMPL(a_first_is_open_token, out_valid_o && !last_of_run_o,
                   tok_kind_o == KIND_NUMBER || tok_kind_o == KIND_SYMBOL)
  `LTS_ASSERT_NEXT(a_second_follows, out_valid_o && !last_of_run_o && !out_stall_i,
                   out_valid_o)

endmodule
